// ----- rtl/dmm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the dense matrix multiplier.
// No dependencies; used by every module of the block but dmm_ram.
package dmm_pkg;

   localparam int CFG_W = 4;
   localparam int IDX_W = 3;
   localparam int ELEM_W = 16;
   localparam int SUM_W = 38;

   typedef enum logic [1:0] {
      FUNC_LOAD_A = 2'd0,
      FUNC_LOAD_B = 2'd1,
      FUNC_START  = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      CSR_ROWS_A    = 2'd0,
      CSR_INNER_DIM = 2'd1,
      CSR_COLS_B    = 2'd2,
      CSR_UNUSED    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [1:0]               func;
      logic [IDX_W-1:0]         row_index;
      logic [IDX_W-1:0]         col_index;
      logic signed [ELEM_W-1:0] element_value;
   } req_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] product_value;
      logic [IDX_W-1:0]        out_row;
      logic [IDX_W-1:0]        out_col;
      logic                    last_of_run;
   } rsp_type;

   // Tag that follows one product term through the read and multiply stages.
   typedef struct packed {
      logic             first_k;
      logic             last_k;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic             last_run;
   } tag_type;

   // Partial sum of one C element as it walks down the cell chain.
   typedef struct packed {
      logic                    valid;
      logic                    done;
      logic [IDX_W-1:0]        row;
      logic [IDX_W-1:0]        col;
      logic                    last_run;
      logic signed [SUM_W-1:0] sum;
   } tok_type;

   // Zero acts as one, anything above the maximum acts as the maximum.
   function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W-1:0] max_dim);
      logic [CFG_W-1:0] r;
      r = v;
      if (v == '0) r = CFG_W'(1);
      else if (v > max_dim) r = max_dim;
      return r;
   endfunction

endpackage

// ----- rtl/dmm_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port RAM with registered read.
// No dependencies.
module dmm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/dmm_cell.sv -----
`timescale 1ns / 1ps
// One accumulate cell of the chain: adds the current product term to the
// partial sum handed over by its neighbor. Depends on dmm_pkg.
module dmm_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  dmm_pkg::tok_type                 tok_i,
   input  logic signed [dmm_pkg::SUM_W-1:0] prod,
   input  logic                             prod_last_k,
   output dmm_pkg::tok_type                 tok_o
);

   dmm_pkg::tok_type tok_ff;
   dmm_pkg::tok_type tok_in;

   always_comb begin
      tok_in = tok_i;
      // a finished sum passes through untouched
      if (!tok_i.done) begin
         tok_in.sum  = tok_i.sum + prod;
         tok_in.done = prod_last_k;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.done     <= tok_in.done;
      tok_ff.row      <= tok_in.row;
      tok_ff.col      <= tok_in.col;
      tok_ff.last_run <= tok_in.last_run;
      tok_ff.sum      <= tok_in.sum;
   end

   assign tok_o = tok_ff;

endmodule

// ----- rtl/dense_matrix_multiply_top.sv -----
`timescale 1ns / 1ps
// Top level of the dense matrix multiplier: element stores, term sequencer,
// multiply stage and accumulate chain. Depends on dmm_pkg, dmm_ram, dmm_cell.
//
// A load beat (func 0 or 1) writes one Q8.8 element of A or B; busy stays
// low. A start beat raises busy for term issue and the drain of the chain:
// one product term is read from the two single-port stores and multiplied
// per cycle, and the partial sums walk a chain of MAX_DIM accumulate cells.
// C elements leave row-major, each with rsp_valid high for one cycle; the
// receiver cannot stall, so sample rsp_payload whenever rsp_valid is high.
module dense_matrix_multiply_top #(
   parameter int MAX_DIM = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  dmm_pkg::req_type          req_payload,
   output logic                      rsp_valid,
   output dmm_pkg::rsp_type          rsp_payload,
   input  logic                      csr_we,
   input  logic [1:0]                csr_index,
   input  logic [dmm_pkg::CFG_W-1:0] csr_wdata
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW = $clog2(DEPTH);
   localparam int CW = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
   localparam logic [dmm_pkg::CFG_W-1:0] MAX_CFG = dmm_pkg::CFG_W'(MAX_DIM);

   logic [dmm_pkg::CFG_W-1:0] rows_ff, inner_ff, cols_ff;
   logic [dmm_pkg::CFG_W-1:0] m_ff, n_ff, p_ff;
   logic [CW-1:0] i_ff, j_ff, k_ff;
   logic running_ff;
   logic accept, load_ok, we_a, we_b;
   logic last_k, last_j, last_i;
   logic [AW-1:0] load_addr, addr_a, addr_b;
   logic [dmm_pkg::ELEM_W-1:0] rd_a, rd_b;
   logic v1_ff, v2_ff;
   dmm_pkg::tag_type tag_issue, tag1_ff, tag2_ff;
   logic signed [dmm_pkg::SUM_W-1:0] prod_ff;
   dmm_pkg::tok_type chain_in;
   dmm_pkg::tok_type tok [MAX_DIM];
   logic chain_busy;

   assign accept = start && !busy;
   assign load_ok = (32'(req_payload.row_index) < MAX_DIM)
                 && (32'(req_payload.col_index) < MAX_DIM);
   assign we_a = accept && load_ok && (req_payload.func == dmm_pkg::FUNC_LOAD_A);
   assign we_b = accept && load_ok && (req_payload.func == dmm_pkg::FUNC_LOAD_B);
   assign load_addr = AW'(req_payload.row_index * MAX_DIM + req_payload.col_index);

   assign last_k = (dmm_pkg::CFG_W'(k_ff) + dmm_pkg::CFG_W'(1)) == n_ff;
   assign last_j = (dmm_pkg::CFG_W'(j_ff) + dmm_pkg::CFG_W'(1)) == p_ff;
   assign last_i = (dmm_pkg::CFG_W'(i_ff) + dmm_pkg::CFG_W'(1)) == m_ff;

   always_comb begin
      if (running_ff) begin
         addr_a = AW'(i_ff * MAX_DIM + k_ff);
         addr_b = AW'(k_ff * MAX_DIM + j_ff);
      end else begin
         addr_a = load_addr;
         addr_b = load_addr;
      end
   end

   always_comb begin
      tag_issue.first_k  = (k_ff == '0);
      tag_issue.last_k   = last_k;
      tag_issue.row      = dmm_pkg::IDX_W'(i_ff);
      tag_issue.col      = dmm_pkg::IDX_W'(j_ff);
      tag_issue.last_run = last_i && last_j;
   end

   dmm_ram #(.WIDTH(dmm_pkg::ELEM_W), .DEPTH(DEPTH)) u_store_a (
      .clock(clock), .we(we_a), .addr(addr_a),
      .wdata(req_payload.element_value), .rdata(rd_a)
   );

   dmm_ram #(.WIDTH(dmm_pkg::ELEM_W), .DEPTH(DEPTH)) u_store_b (
      .clock(clock), .we(we_b), .addr(addr_b),
      .wdata(req_payload.element_value), .rdata(rd_b)
   );

   // Registers and term sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff    <= MAX_CFG;
         inner_ff   <= MAX_CFG;
         cols_ff    <= MAX_CFG;
         running_ff <= 1'b0;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         i_ff       <= '0;
         j_ff       <= '0;
         k_ff       <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               dmm_pkg::CSR_ROWS_A:    rows_ff  <= csr_wdata;
               dmm_pkg::CSR_INNER_DIM: inner_ff <= csr_wdata;
               dmm_pkg::CSR_COLS_B:    cols_ff  <= csr_wdata;
               default: ;
            endcase
         end
         v1_ff <= running_ff;
         v2_ff <= v1_ff;
         if (accept && req_payload.func == dmm_pkg::FUNC_START) begin
            running_ff <= 1'b1;
            i_ff <= '0;
            j_ff <= '0;
            k_ff <= '0;
         end else if (running_ff) begin
            if (!last_k) begin
               k_ff <= k_ff + CW'(1);
            end else begin
               k_ff <= '0;
               if (!last_j) begin
                  j_ff <= j_ff + CW'(1);
               end else begin
                  j_ff <= '0;
                  if (last_i) running_ff <= 1'b0;
                  else i_ff <= i_ff + CW'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_payload.func == dmm_pkg::FUNC_START) begin
         m_ff <= dmm_pkg::clamp_dim(rows_ff, MAX_CFG);
         n_ff <= dmm_pkg::clamp_dim(inner_ff, MAX_CFG);
         p_ff <= dmm_pkg::clamp_dim(cols_ff, MAX_CFG);
      end
      tag1_ff <= tag_issue;
      tag2_ff <= tag1_ff;
      prod_ff <= dmm_pkg::SUM_W'($signed(rd_a) * $signed(rd_b));
   end

   // A new sum enters the chain with its first term
   always_comb begin
      chain_in.valid    = v2_ff && tag2_ff.first_k;
      chain_in.done     = 1'b0;
      chain_in.row      = tag2_ff.row;
      chain_in.col      = tag2_ff.col;
      chain_in.last_run = tag2_ff.last_run;
      chain_in.sum      = '0;
   end

   for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
      dmm_cell u_cell (
         .clock(clock), .reset(reset),
         .tok_i((c == 0) ? chain_in : tok[(c == 0) ? 0 : c - 1]),
         .prod(prod_ff), .prod_last_k(tag2_ff.last_k),
         .tok_o(tok[c])
      );
   end

   always_comb begin
      chain_busy = 1'b0;
      for (int c = 0; c < MAX_DIM; c++) begin
         chain_busy = chain_busy | tok[c].valid;
      end
   end

   assign busy = running_ff || v1_ff || v2_ff || chain_busy;

   assign rsp_valid = tok[MAX_DIM-1].valid;
   always_comb begin
      rsp_payload.product_value = tok[MAX_DIM-1].sum;
      rsp_payload.out_row       = tok[MAX_DIM-1].row;
      rsp_payload.out_col       = tok[MAX_DIM-1].col;
      rsp_payload.last_of_run   = tok[MAX_DIM-1].last_run;
   end

endmodule

// ----- rtl/dmm_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the dense matrix multiplier, bound to the top level.
// Depends on dmm_pkg and dense_matrix_multiply_top.
module dmm_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input dmm_pkg::req_type req_payload,
   input logic             rsp_valid,
   input dmm_pkg::rsp_type rsp_payload
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !busy && !rsp_valid)
      else $error("block not idle after reset");

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result beat while idle");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_payload.func != dmm_pkg::FUNC_START) |=> !busy)
      else $error("load beat made the block busy");

   a_last_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.last_of_run) |=> !rsp_valid)
      else $error("result beat after the last of a run");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_payload.func == dmm_pkg::FUNC_START) |=> busy)
      else $error("start beat did not raise busy");

endmodule

bind dense_matrix_multiply_top dmm_checker u_dmm_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .req_payload(req_payload), .rsp_valid(rsp_valid), .rsp_payload(rsp_payload)
);
